@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the maze generator RTL.
// No dependencies; the files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MBG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("maze generator assertion failed");
`define MBG_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("maze generator forbidden condition");
`else
`define MBG_ASSERT(lbl, clk, rst_n, prop)
`define MBG_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

@@ hw/rtl/mbg_pkg.sv @@
// Shared types, codes and the direction order table of the maze generator.
// No dependencies; imported by the controller, the datapath and the top level.
package mbg_pkg;

	localparam int CFG_AW      = 3;
	localparam int CFG_DW      = 7;
	localparam int ORDER_W     = 5;
	localparam int COORD_OUT_W = 6;
	localparam int EXT_W       = 9;

	localparam logic [CFG_AW-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_AW-1:0] REG_GRID_HEIGHT = 3'd1;
	localparam logic [CFG_AW-1:0] REG_START_COL   = 3'd2;
	localparam logic [CFG_AW-1:0] REG_START_ROW   = 3'd3;
	localparam logic [CFG_AW-1:0] REG_EXIT_COL    = 3'd4;
	localparam logic [CFG_AW-1:0] REG_EXIT_ROW    = 3'd5;

	localparam logic [ORDER_W-1:0] ORDER_COUNT = 5'd24;

	localparam logic ACT_START = 1'b0;

	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	localparam logic [1:0] RES_START = 2'd0;
	localparam logic [1:0] RES_WALL  = 2'd1;
	localparam logic [1:0] RES_CELL  = 2'd2;
	localparam logic [1:0] RES_EXIT  = 2'd3;

	// Each entry packs four directions, first one tried in bits [1:0].
	localparam logic [7:0] PERM_TABLE [0:23] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};

	typedef struct packed {
		logic [6:0] grid_width;
		logic [6:0] grid_height;
		logic [5:0] start_col;
		logic [5:0] start_row;
		logic [5:0] exit_col;
		logic [5:0] exit_row;
	} cfg_t;

	typedef struct packed {
		logic       load_in;
		logic       clr_step;
		logic       start_open;
		logic       next_try;
		logic       rd_issue;
		logic       carve_wall;
		logic       carve_cell;
		logic       pop;
		logic       top_load;
		logic       emit;
		logic [1:0] res_sel;
	} cmd_t;

	typedef struct packed {
		logic carving;
		logic clr_last;
		logic cand_ok;
		logic cand_wall;
		logic last_try;
		logic depth_one;
		logic out_free;
	} sts_t;

	function automatic logic [1:0] perm_dir(input logic [ORDER_W-1:0] order,
	                                        input logic [1:0] slot);
		logic [7:0] row;
		row = (order < ORDER_COUNT) ? PERM_TABLE[order] : PERM_TABLE[0];
		return row[{slot, 1'b0} +: 2];
	endfunction

endpackage

@@ hw/rtl/maze_backtracker_generator.sv @@
// Top level of the depth-first maze generator: stream ports, configuration
// registers, controller and datapath. Depends on mbg_pkg, mbg_ctrl and mbg_datapath.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+--------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | s_tuser action, s_tdata visit_order
//  m_*      | out | m_tvalid / m_tready     | m_tdata col,row; m_tuser kind,done; m_tlast
//  cfg_*    | in  | cfg_we (no wait)        | cfg_addr register index, cfg_wdata value
//
// A start word sweeps the wall map back to walls one entry per cycle through its
// single write port, then opens the start cell. A step word tries neighbors in turn,
// with a wall map read for each one inside the grid; then carving and emission or
// the pop follow. A step word while no maze is being carved is ignored.
// No clearing pass after reset; reset clears the control state and m_tvalid.
// A new word is taken once the previous one has finished and put any last result in
// the output register; the block waits while it is full and m_tready is low.
module maze_backtracker_generator
	import mbg_pkg::*;
#(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 64,
	parameter int STACK_DEPTH = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [4:0] visit_order, [7:5] zero
	input  logic              s_tuser,   // [0] action
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,   // [5:0] cell_col, [11:6] cell_row, [15:12] zero
	output logic [1:0]        m_tuser,   // [0] cell_kind, [1] done_res
	output logic              m_tlast,
	input  logic              cfg_we,
	input  logic [CFG_AW-1:0] cfg_addr,
	input  logic [CFG_DW-1:0] cfg_wdata
);

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	logic [COORD_OUT_W-1:0] out_col, out_row;
	logic                   out_kind, out_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= 7'd21;
			cfg_q.grid_height <= 7'd21;
			cfg_q.start_col   <= 6'd1;
			cfg_q.start_row   <= 6'd1;
			cfg_q.exit_col    <= 6'd19;
			cfg_q.exit_row    <= 6'd19;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_wdata;
				REG_GRID_HEIGHT: cfg_q.grid_height <= cfg_wdata;
				REG_START_COL:   cfg_q.start_col   <= cfg_wdata[5:0];
				REG_START_ROW:   cfg_q.start_row   <= cfg_wdata[5:0];
				REG_EXIT_COL:    cfg_q.exit_col    <= cfg_wdata[5:0];
				REG_EXIT_ROW:    cfg_q.exit_row    <= cfg_wdata[5:0];
				default: begin
				end
			endcase
		end
	end

	mbg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_action (s_tuser),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbg_datapath #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_order  (s_tdata[ORDER_W-1:0]),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_col   (out_col),
		.out_row   (out_row),
		.out_kind  (out_kind),
		.out_last  (m_tlast),
		.out_done  (out_done)
	);

	assign m_tdata = {4'b0000, out_row, out_col};
	assign m_tuser = {out_done, out_kind};

endmodule

@@ hw/rtl/mbg_ctrl.sv @@
// Sequencing state machine of the maze generator: start sweep, neighbor tries,
// carving, popping and result emission. Depends on mbg_pkg and assert_macros.svh.
`include "assert_macros.svh"
module mbg_ctrl
	import mbg_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_action,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_CLR        = 4'd1;
	localparam logic [3:0] ST_START      = 4'd2;
	localparam logic [3:0] ST_EMIT_START = 4'd3;
	localparam logic [3:0] ST_TRY        = 4'd4;
	localparam logic [3:0] ST_CHECK      = 4'd5;
	localparam logic [3:0] ST_CARVE1     = 4'd6;
	localparam logic [3:0] ST_CARVE2     = 4'd7;
	localparam logic [3:0] ST_EMIT_W     = 4'd8;
	localparam logic [3:0] ST_EMIT_C     = 4'd9;
	localparam logic [3:0] ST_POP        = 4'd10;
	localparam logic [3:0] ST_POPW       = 4'd11;
	localparam logic [3:0] ST_EMIT_EXIT  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (in_action == ACT_START) begin
						state_d = ST_CLR;
					end else if (sts.carving) begin
						state_d = ST_TRY;
					end
				end
			end
			ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.start_open = 1'b1;
				state_d        = ST_EMIT_START;
			end
			ST_EMIT_START: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_START;
					state_d     = ST_IDLE;
				end
			end
			ST_TRY: begin
				if (sts.cand_ok) begin
					cmd.rd_issue = 1'b1;
					state_d      = ST_CHECK;
				end else if (sts.last_try) begin
					state_d = ST_POP;
				end else begin
					cmd.next_try = 1'b1;
				end
			end
			ST_CHECK: begin
				if (sts.cand_wall) begin
					state_d = ST_CARVE1;
				end else if (sts.last_try) begin
					state_d = ST_POP;
				end else begin
					cmd.next_try = 1'b1;
					state_d      = ST_TRY;
				end
			end
			ST_CARVE1: begin
				cmd.carve_wall = 1'b1;
				state_d        = ST_CARVE2;
			end
			ST_CARVE2: begin
				cmd.carve_cell = 1'b1;
				state_d        = ST_EMIT_W;
			end
			ST_EMIT_W: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_WALL;
					state_d     = ST_EMIT_C;
				end
			end
			ST_EMIT_C: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_CELL;
					state_d     = ST_IDLE;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = sts.depth_one ? ST_EMIT_EXIT : ST_POPW;
			end
			ST_POPW: begin
				cmd.top_load = 1'b1;
				state_d      = ST_IDLE;
			end
			ST_EMIT_EXIT: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.res_sel = RES_EXIT;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`MBG_ASSERT(a_emit_when_free, clk, arst_n, cmd.emit |-> sts.out_free)
	`MBG_ASSERT(a_check_after_read, clk, arst_n, (state_q == ST_CHECK) |-> $past(cmd.rd_issue))
	`MBG_ASSERT(a_cell_after_wall, clk, arst_n, cmd.carve_cell |-> $past(cmd.carve_wall))

endmodule

@@ hw/rtl/mbg_datapath.sv @@
// Maze generator datapath: wall map memory, cell stack memory, stack top, candidate
// neighbor logic, counters, output word register. Uses mbg_pkg, assert_macros.svh.
`include "assert_macros.svh"
module mbg_datapath
	import mbg_pkg::*;
#(
	parameter int MAX_COLS    = 64,
	parameter int MAX_ROWS    = 64,
	parameter int STACK_DEPTH = 1024
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cfg_t                   cfg,
	input  logic [ORDER_W-1:0]     in_order,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_OUT_W-1:0] out_col,
	output logic [COORD_OUT_W-1:0] out_row,
	output logic                   out_kind,
	output logic                   out_last,
	output logic                   out_done
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int CELLS = MAX_COLS * MAX_ROWS;
	localparam int MA_W  = $clog2(CELLS);
	localparam int SA_W  = $clog2(STACK_DEPTH);
	localparam int D_W   = $clog2(STACK_DEPTH + 1);
	localparam int SE_W  = COL_W + ROW_W;

	function automatic logic [MA_W-1:0] cell_addr(input logic [COL_W-1:0] col,
	                                             input logic [ROW_W-1:0] row);
		return MA_W'(MA_W'(row) * MA_W'(MAX_COLS) + MA_W'(col));
	endfunction

	logic             map_q [CELLS];
	logic [SE_W-1:0]  stack_q [STACK_DEPTH];

	logic [ORDER_W-1:0] order_q;
	logic [1:0]         try_q;
	logic [MA_W-1:0]    clr_q;
	logic [D_W-1:0]     depth_q;
	logic               carving_q;
	logic [COL_W-1:0]   top_col_q;
	logic [ROW_W-1:0]   top_row_q;
	logic [COL_W-1:0]   cm_col_q, cn_col_q;
	logic [ROW_W-1:0]   cm_row_q, cn_row_q;
	logic               map_rd_q;
	logic [SE_W-1:0]    stack_rd_q;

	logic [EXT_W-1:0] w_used, h_used, sc_ext, sr_ext, x_ext, y_ext;
	logic [COL_W-1:0] start_col, m_col, n_col;
	logic [ROW_W-1:0] start_row, m_row, n_row;
	logic [1:0]       dir;
	logic             cand_ok;
	logic             full;
	logic             push;

	logic             map_we, map_wd;
	logic [MA_W-1:0]  map_wa;
	logic             stk_we;
	logic [SA_W-1:0]  stk_wa;
	logic [SE_W-1:0]  stk_wd;

	// Grid extent in use and the start cell pulled inside it
	always_comb begin
		w_used = EXT_W'(cfg.grid_width);
		if (w_used > EXT_W'(MAX_COLS)) w_used = EXT_W'(MAX_COLS);
		if (w_used == '0) w_used = EXT_W'(1);
		h_used = EXT_W'(cfg.grid_height);
		if (h_used > EXT_W'(MAX_ROWS)) h_used = EXT_W'(MAX_ROWS);
		if (h_used == '0) h_used = EXT_W'(1);
		sc_ext = EXT_W'(cfg.start_col);
		if (sc_ext > w_used - EXT_W'(1)) sc_ext = w_used - EXT_W'(1);
		sr_ext = EXT_W'(cfg.start_row);
		if (sr_ext > h_used - EXT_W'(1)) sr_ext = h_used - EXT_W'(1);
	end

	assign start_col = COL_W'(sc_ext);
	assign start_row = ROW_W'(sr_ext);

	// Candidate neighbor two cells away and the wall between
	always_comb begin
		dir   = perm_dir(order_q, try_q);
		x_ext = EXT_W'(top_col_q);
		y_ext = EXT_W'(top_row_q);
		m_col = top_col_q;
		n_col = top_col_q;
		m_row = top_row_q;
		n_row = top_row_q;
		case (dir)
			DIR_UP: begin
				cand_ok = y_ext >= EXT_W'(2);
				m_row   = top_row_q - ROW_W'(1);
				n_row   = top_row_q - ROW_W'(2);
			end
			DIR_RIGHT: begin
				cand_ok = (x_ext + EXT_W'(2)) < w_used;
				m_col   = top_col_q + COL_W'(1);
				n_col   = top_col_q + COL_W'(2);
			end
			DIR_DOWN: begin
				cand_ok = (y_ext + EXT_W'(2)) < h_used;
				m_row   = top_row_q + ROW_W'(1);
				n_row   = top_row_q + ROW_W'(2);
			end
			default: begin
				cand_ok = x_ext >= EXT_W'(2);
				m_col   = top_col_q - COL_W'(1);
				n_col   = top_col_q - COL_W'(2);
			end
		endcase
	end

	assign full = depth_q == D_W'(STACK_DEPTH);
	assign push = cmd.carve_cell && !full;

	// Wall map write port
	always_comb begin
		map_we = 1'b1;
		map_wd = 1'b0;
		map_wa = clr_q;
		if (cmd.clr_step) begin
			map_wd = 1'b1;
		end else if (cmd.start_open) begin
			map_wa = cell_addr(start_col, start_row);
		end else if (cmd.carve_wall) begin
			map_wa = cell_addr(cm_col_q, cm_row_q);
		end else if (cmd.carve_cell) begin
			map_wa = cell_addr(cn_col_q, cn_row_q);
		end else begin
			map_we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) map_q[map_wa] <= map_wd;
		if (cmd.rd_issue) map_rd_q <= map_q[cell_addr(n_col, n_row)];
	end

	// Cell stack write port
	always_comb begin
		stk_we = cmd.start_open || push;
		stk_wa = depth_q[SA_W-1:0];
		stk_wd = {cn_row_q, cn_col_q};
		if (cmd.start_open) begin
			stk_wa = '0;
			stk_wd = {start_row, start_col};
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) stack_q[stk_wa] <= stk_wd;
		if (cmd.pop && !sts.depth_one) stack_rd_q <= stack_q[SA_W'(depth_q - D_W'(2))];
	end

	// Payload: order, candidate cells, stack top
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			order_q <= (in_order >= ORDER_COUNT) ? in_order - ORDER_COUNT : in_order;
		end
		if (cmd.rd_issue) begin
			cm_col_q <= m_col;
			cm_row_q <= m_row;
			cn_col_q <= n_col;
			cn_row_q <= n_row;
		end
		if (cmd.start_open) begin
			top_col_q <= start_col;
			top_row_q <= start_row;
		end else if (push) begin
			top_col_q <= cn_col_q;
			top_row_q <= cn_row_q;
		end else if (cmd.top_load) begin
			top_col_q <= stack_rd_q[COL_W-1:0];
			top_row_q <= stack_rd_q[SE_W-1:COL_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			try_q     <= '0;
			clr_q     <= '0;
			depth_q   <= '0;
			carving_q <= 1'b0;
		end else begin
			if (cmd.load_in) begin
				try_q <= '0;
				clr_q <= '0;
			end else begin
				if (cmd.next_try) try_q <= try_q + 2'd1;
				if (cmd.clr_step) clr_q <= clr_q + MA_W'(1);
			end
			if (cmd.start_open) begin
				depth_q   <= D_W'(1);
				carving_q <= 1'b1;
			end else if (push) begin
				depth_q <= depth_q + D_W'(1);
			end else if (cmd.pop) begin
				depth_q <= depth_q - D_W'(1);
				if (sts.depth_one) carving_q <= 1'b0;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			case (cmd.res_sel)
				RES_START: begin
					out_col  <= COORD_OUT_W'(top_col_q);
					out_row  <= COORD_OUT_W'(top_row_q);
					out_kind <= 1'b0;
					out_last <= 1'b1;
					out_done <= 1'b0;
				end
				RES_WALL: begin
					out_col  <= COORD_OUT_W'(cm_col_q);
					out_row  <= COORD_OUT_W'(cm_row_q);
					out_kind <= 1'b0;
					out_last <= 1'b0;
					out_done <= 1'b0;
				end
				RES_CELL: begin
					out_col  <= COORD_OUT_W'(cn_col_q);
					out_row  <= COORD_OUT_W'(cn_row_q);
					out_kind <= 1'b0;
					out_last <= 1'b1;
					out_done <= 1'b0;
				end
				default: begin
					out_col  <= cfg.exit_col;
					out_row  <= cfg.exit_row;
					out_kind <= 1'b1;
					out_last <= 1'b1;
					out_done <= 1'b1;
				end
			endcase
		end
	end

	assign sts.carving   = carving_q;
	assign sts.clr_last  = clr_q == MA_W'(CELLS - 1);
	assign sts.cand_ok   = cand_ok;
	assign sts.cand_wall = map_rd_q;
	assign sts.last_try  = try_q == 2'd3;
	assign sts.depth_one = depth_q == D_W'(1);
	assign sts.out_free  = !out_valid || out_ready;

	`MBG_ASSERT(a_depth_bounded, clk, arst_n, depth_q <= D_W'(STACK_DEPTH))
	`MBG_NEVER(a_carving_has_cells, clk, arst_n, carving_q && (depth_q == '0))

endmodule
